>>> design/aes_pkg.sv
// Package: AES S-box table, byte and round helpers shared by the cipher modules.
`default_nettype none
package aes_pkg;

    localparam int MAX_ROUND_KEYS_DEF = 15;
    localparam logic [7:0] RCON_INIT = 8'h01;
    localparam logic [7:0] XTIME_POLY = 8'h1b;

    typedef enum logic {
        EXP_RUN,
        EXP_READY
    } exp_state_t;

    typedef enum logic [2:0] {
        CFG_KEY_SIZE = 3'd0,
        CFG_KEY_A    = 3'd1,
        CFG_KEY_B    = 3'd2,
        CFG_KEY_C    = 3'd3,
        CFG_KEY_D    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic active;
        logic mix;
    } round_ctrl_t;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? XTIME_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] t);
        return {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
    endfunction

    // byte k of a block sits at bits 127-8k downto 120-8k
    function automatic logic [127:0] cipher_round(input logic [127:0] s, input logic mix);
        logic [7:0] sb [16];
        logic [7:0] tb [16];
        logic [7:0] all;
        logic [127:0] res;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sb[r + 4 * c] = SBOX[s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            all = sb[4 * c] ^ sb[4 * c + 1] ^ sb[4 * c + 2] ^ sb[4 * c + 3];
            for (int r = 0; r < 4; r++) begin
                tb[4 * c + r] = mix ? (sb[4 * c + r] ^ all ^
                    xtime(sb[4 * c + r] ^ sb[4 * c + ((r + 1) % 4)])) : sb[4 * c + r];
            end
        end
        for (int k = 0; k < 16; k++) begin
            res[127 - 8 * k -: 8] = tb[k];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

>>> design/aes_block_encrypt.sv
// Top level: AES-128/192/256 block encryption, one round per pipeline stage.
//
//  channel | ports                                   | direction
//  s_      | s_valid s_ready s_plain_high s_plain_low | plaintext word in
//  m_      | m_valid m_ready m_cipher_high m_cipher_low | ciphertext word out
//  cfg_    | cfg_wr_en cfg_index cfg_wdata            | register write
//
// One word per cycle while the output is not stalled; a key-add stage plus one stage per round.
// Key schedule runs one key word per cycle, 4*(Nr+1) words in all, after reset or a key register write,
// while s_ready stays low.
// A stalled output stalls all stages; nothing is dropped or repeated.
`default_nettype none
module aes_block_encrypt #(
    parameter int MAX_ROUND_KEYS = aes_pkg::MAX_ROUND_KEYS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [63:0]  cfg_wdata,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [63:0]  s_plain_high,
    input  wire logic [63:0]  s_plain_low,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [63:0]       m_cipher_high,
    output logic [63:0]       m_cipher_low
);
    localparam int NR_MAX = MAX_ROUND_KEYS - 1;

    logic         keys_ready;
    logic [3:0]   round_count;
    logic [MAX_ROUND_KEYS-1:0][127:0] round_keys;
    logic         advance;
    logic         v_reg;
    logic [127:0] d_reg;
    logic         v_pipe [MAX_ROUND_KEYS];
    logic [127:0] d_pipe [MAX_ROUND_KEYS];

    aes_key_sched #(.MAX_ROUND_KEYS(MAX_ROUND_KEYS)) u_key (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .keys_ready  (keys_ready),
        .round_count (round_count),
        .round_keys  (round_keys)
    );

    assign advance = !m_valid || m_ready;
    assign s_ready = keys_ready && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (advance) begin
            v_reg <= s_valid && keys_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            d_reg <= {s_plain_high, s_plain_low} ^ round_keys[0];
        end
    end

    assign v_pipe[0] = v_reg;
    assign d_pipe[0] = d_reg;

    for (genvar r = 1; r <= NR_MAX; r++) begin : g_round
        aes_pkg::round_ctrl_t ctrl;
        assign ctrl.active = (4'(r) <= round_count);
        assign ctrl.mix    = (4'(r) < round_count);
        aes_round u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .ctrl      (ctrl),
            .round_key (round_keys[r]),
            .valid_in  (v_pipe[r-1]),
            .data_in   (d_pipe[r-1]),
            .valid_out (v_pipe[r]),
            .data_out  (d_pipe[r])
        );
    end

    assign m_valid       = v_pipe[NR_MAX];
    assign m_cipher_high = d_pipe[NR_MAX][127:64];
    assign m_cipher_low  = d_pipe[NR_MAX][63:0];

    a_ready_keys : assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> keys_ready)
        else $error("input taken without round keys");
    a_out_keys : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> keys_ready)
        else $error("result present while keys not ready");
    a_rounds : assert property (@(posedge aclk) disable iff (!aresetn)
        keys_ready |-> (round_count == 4'd10 || round_count == 4'd12 || round_count == 4'd14))
        else $error("bad round count");
    a_stall : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(v_pipe[0]))
        else $error("pipeline moved during stall");

endmodule
`default_nettype wire

>>> design/aes_key_expand.sv
// Key registers and iterative key schedule, one key word per cycle.
`default_nettype none
module aes_key_sched #(
    parameter int MAX_ROUND_KEYS = aes_pkg::MAX_ROUND_KEYS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [63:0]  cfg_wdata,
    output logic              keys_ready,
    output logic [3:0]        round_count,
    output logic [MAX_ROUND_KEYS-1:0][127:0] round_keys
);
    localparam int IW = $clog2(4 * MAX_ROUND_KEYS);

    aes_pkg::exp_state_t state_reg, state_next;
    logic [1:0]  key_size_reg;
    logic [63:0] key_a_reg, key_b_reg, key_c_reg, key_d_reg;
    logic [IW-1:0] word_reg, word_next;
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  rcon_reg, rcon_next;
    logic [31:0] win_reg [8];
    logic [MAX_ROUND_KEYS-1:0][127:0] rk_reg;
    logic        cfg_hit;
    logic [1:0]  mode;
    logic [2:0]  nk_m1;
    logic [255:0] key_all;
    logic [31:0] t_word, new_word;
    logic        in_key;

    assign cfg_hit = cfg_wr_en && (cfg_index <= aes_pkg::CFG_KEY_D);

    always_comb begin
        mode = (key_size_reg == 2'd3) ? 2'd2 : key_size_reg;
        if (mode == 2'd2 && MAX_ROUND_KEYS < 15) begin
            mode = 2'd1;
        end
        if (mode == 2'd1 && MAX_ROUND_KEYS < 13) begin
            mode = 2'd0;
        end
    end

    assign round_count = 4'd10 + {1'b0, mode, 1'b0};
    assign nk_m1 = 3'd3 + {mode, 1'b0};
    assign key_all = {key_a_reg, key_b_reg, key_c_reg, key_d_reg};
    assign in_key = ({{(IW-3){1'b0}}, nk_m1} >= word_reg);

    always_comb begin
        t_word = win_reg[0];
        rcon_next = rcon_reg;
        if (!in_key && phase_reg == 3'd0) begin
            t_word = aes_pkg::sub_word({win_reg[0][23:0], win_reg[0][31:24]}) ^
                     {rcon_reg, 24'd0};
            rcon_next = aes_pkg::xtime(rcon_reg);
        end else if (!in_key && mode == 2'd2 && phase_reg == 3'd4) begin
            t_word = aes_pkg::sub_word(win_reg[0]);
        end
        new_word = in_key ? key_all[{~word_reg[2:0], 5'd0} +: 32] : (win_reg[nk_m1] ^ t_word);
        phase_next = (phase_reg == nk_m1) ? 3'd0 : phase_reg + 3'd1;
        word_next = word_reg + IW'(1);
        state_next = state_reg;
        unique case (state_reg)
            aes_pkg::EXP_RUN: begin
                if (word_reg == IW'({round_count, 2'b11})) begin
                    state_next = aes_pkg::EXP_READY;
                end
            end
            aes_pkg::EXP_READY: begin
                state_next = aes_pkg::EXP_READY;
            end
            default: state_next = aes_pkg::EXP_RUN;
        endcase
        if (cfg_hit) begin
            state_next = aes_pkg::EXP_RUN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= aes_pkg::EXP_RUN;
            key_size_reg <= 2'd0;
            key_a_reg    <= 64'd0;
            key_b_reg    <= 64'd0;
            key_c_reg    <= 64'd0;
            key_d_reg    <= 64'd0;
            word_reg     <= '0;
            phase_reg    <= 3'd0;
            rcon_reg     <= aes_pkg::RCON_INIT;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    aes_pkg::CFG_KEY_SIZE: key_size_reg <= cfg_wdata[1:0];
                    aes_pkg::CFG_KEY_A:    key_a_reg <= cfg_wdata;
                    aes_pkg::CFG_KEY_B:    key_b_reg <= cfg_wdata;
                    aes_pkg::CFG_KEY_C:    key_c_reg <= cfg_wdata;
                    aes_pkg::CFG_KEY_D:    key_d_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cfg_hit) begin
                word_reg  <= '0;
                phase_reg <= 3'd0;
                rcon_reg  <= aes_pkg::RCON_INIT;
            end else if (state_reg == aes_pkg::EXP_RUN) begin
                word_reg  <= word_next;
                phase_reg <= phase_next;
                rcon_reg  <= rcon_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == aes_pkg::EXP_RUN && !cfg_hit) begin
            win_reg[0] <= new_word;
            for (int j = 1; j < 8; j++) begin
                win_reg[j] <= win_reg[j-1];
            end
            rk_reg[word_reg[IW-1:2]][{~word_reg[1:0], 5'd0} +: 32] <= new_word;
        end
    end

    assign keys_ready = (state_reg == aes_pkg::EXP_READY);
    assign round_keys = rk_reg;

endmodule
`default_nettype wire

>>> design/aes_round.sv
// One pipelined cipher round: SubBytes, ShiftRows, optional MixColumns, key add; passes data through when inactive.
`default_nettype none
module aes_round (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          advance,
    input  wire aes_pkg::round_ctrl_t ctrl,
    input  wire logic [127:0]  round_key,
    input  wire logic          valid_in,
    input  wire logic [127:0]  data_in,
    output logic               valid_out,
    output logic [127:0]       data_out
);
    logic         valid_reg;
    logic [127:0] data_reg, data_next;

    assign data_next = ctrl.active ?
        (aes_pkg::cipher_round(data_in, ctrl.mix) ^ round_key) : data_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule
`default_nettype wire
